// ----- src/swerve_four_wheel_kinematics_core_assert.svh -----
// ----------------------------------------------------------------------------
// Swerve kinematics assertion macros
// Concurrent assertion wrappers that compile away for synthesis.
// ----------------------------------------------------------------------------
`ifndef SWERVE_FOUR_WHEEL_KINEMATICS_CORE_ASSERT_SVH
`define SWERVE_FOUR_WHEEL_KINEMATICS_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define SWK_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define SWK_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SWK_ASSERT(lbl, clk, rst_n, prop, msg)
`define SWK_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// ----- src/swk_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Swerve kinematics package
// Shared widths, constants, register indexes and payload types.
// ----------------------------------------------------------------------------
package swk_pkg;

  localparam int VEL_W      = 16;
  localparam int LEN_W      = 16;
  localparam int SCALE_W    = 20;
  localparam int PROD_W     = 33;
  localparam int LEN_SHIFT  = 14;
  localparam int COMP_W     = 19;
  localparam int CDC_W      = 29;
  localparam int CDC_PRESCL = 8;
  localparam int Z_W        = 33;
  localparam int Z_SHIFT    = 17;
  localparam int SQ_W       = 36;
  localparam int RAD_W      = 32;
  localparam int ROOT_W     = 33;
  localparam int ROOT_STEPS = 16;
  localparam int ATAN_LEN   = 24;
  localparam int ANG_W      = 15;
  localparam int SPD_W      = 16;
  localparam int RPM_W      = 8;
  localparam int RPM_SHIFT  = 18;
  localparam int IDX_W      = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int MID_DEPTH  = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_HALF_TRACK = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HALF_BASE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RPM_SCALE  = 2'd2;

  localparam logic [LEN_W-1:0]   HALF_TRACK_RST = 16'd4096;
  localparam logic [LEN_W-1:0]   HALF_BASE_RST  = 16'd4096;
  localparam logic [SCALE_W-1:0] RPM_SCALE_RST  = 20'd48893;

  localparam logic [IDX_W-1:0]        LAST_WHEEL  = 2'd3;
  localparam logic signed [ANG_W-1:0] HALF_PI_Q13 = 15'sd12868;
  localparam logic signed [Z_W-1:0]   Z_ROUND     = 33'sd65536;
  localparam logic [SPD_W-1:0]        SPEED_MAX   = 16'hFFFF;
  localparam logic [RPM_W-1:0]        RPM_MAX     = 8'd255;

  localparam logic [30:0] ATAN_Q30 [ATAN_LEN] = '{
    31'd843314857, 31'd497837829, 31'd263043837, 31'd133525159,
    31'd67021687,  31'd33543516,  31'd16775851,  31'd8388437,
    31'd4194283,   31'd2097149,   31'd1048576,   31'd524288,
    31'd262144,    31'd131072,    31'd65536,     31'd32768,
    31'd16384,     31'd8192,      31'd4096,      31'd2048,
    31'd1024,      31'd512,       31'd256,       31'd128
  };

  typedef struct packed {
    logic [IDX_W-1:0]         idx;
    logic                     w_pos;
    logic signed [COMP_W-1:0] x;
    logic signed [COMP_W-1:0] y;
  } swk_wheel_t;

  typedef struct packed {
    logic [IDX_W-1:0]        wheel_index;
    logic signed [ANG_W-1:0] steer_angle;
    logic [SPD_W-1:0]        wheel_speed;
    logic [RPM_W-1:0]        wheel_rpm;
    logic                    last_wheel;
  } swk_result_t;

  typedef struct packed {
    logic [IDX_W-1:0]        idx;
    logic                    w_pos;
    logic                    x_zero;
    logic                    y_zero;
    logic                    sat;
    logic signed [CDC_W-1:0] cx;
    logic signed [CDC_W-1:0] cy;
    logic signed [Z_W-1:0]   cz;
    logic [RAD_W-1:0]        rem;
    logic [ROOT_W-1:0]       root;
  } swk_iter_t;

endpackage
`default_nettype wire

// ----- src/swerve_four_wheel_kinematics_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Each accepted command yields four wheel results in wheel order 0 to 3, one per
// clock when the consumer keeps popping; the front end emits one wheel vector per
// cycle while the work queue has room, and takes the next command in the cycle
// that it pushes the last wheel of the current one.
// A result passes the front end, the work queue, the CORDIC and square root
// pipeline and the result queue before it appears on the result ports.
// Configuration writes are always ready and must only be issued idle.
// ----------------------------------------------------------------------------
// Swerve four wheel kinematics core
// Top level: configuration registers, front end, work queue, arithmetic back
// end and the result queue with its credit counter.
// ----------------------------------------------------------------------------
`include "swerve_four_wheel_kinematics_core_assert.svh"
module swerve_four_wheel_kinematics_core
  import swk_pkg::*;
#(
  parameter int CORDIC_STEPS = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_push,
  output logic                     in_full,
  input  logic signed [VEL_W-1:0]  in_vel_x,
  input  logic signed [VEL_W-1:0]  in_vel_y,
  input  logic signed [VEL_W-1:0]  in_yaw_rate,
  output logic                     out_empty,
  input  logic                     out_pop,
  output logic [IDX_W-1:0]         out_wheel_index,
  output logic signed [ANG_W-1:0]  out_steer_angle,
  output logic [SPD_W-1:0]         out_wheel_speed,
  output logic [RPM_W-1:0]         out_wheel_rpm,
  output logic                     out_last_wheel,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [SCALE_W-1:0]       cfg_data
);

  localparam int ITER_N    = (CORDIC_STEPS > ROOT_STEPS) ? CORDIC_STEPS : ROOT_STEPS;
  localparam int LATENCY   = ITER_N + 4;
  localparam int OUT_DEPTH = 2 ** $clog2(LATENCY + 1);
  localparam int CNT_W     = $clog2(OUT_DEPTH + 1);
  localparam int MCNT_W    = $clog2(MID_DEPTH + 1);
  localparam int WHEEL_W   = $bits(swk_wheel_t);
  localparam int RES_W     = $bits(swk_result_t);

  logic [LEN_W-1:0]   half_track_r, half_base_r;
  logic [SCALE_W-1:0] rpm_scale_r;

  logic               mid_push, mid_full, mid_empty;
  swk_wheel_t         mid_wr, mid_head;
  logic [WHEEL_W-1:0] mid_rd_data;
  logic [MCNT_W-1:0]  mid_count;

  logic               issue;
  logic               res_valid;
  swk_result_t        res_item, out_head;
  logic [RES_W-1:0]   out_rd_data;
  logic               out_full;
  logic [CNT_W-1:0]   out_count;
  logic [CNT_W-1:0]   inflight_r, inflight_nxt;
  logic [CNT_W:0]     credit_sum;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_track_r <= HALF_TRACK_RST;
      half_base_r  <= HALF_BASE_RST;
      rpm_scale_r  <= RPM_SCALE_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_HALF_TRACK: half_track_r <= cfg_data[LEN_W-1:0];
        CFG_HALF_BASE:  half_base_r  <= cfg_data[LEN_W-1:0];
        CFG_RPM_SCALE:  rpm_scale_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  swk_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_push     (in_push),
    .in_vel_x    (in_vel_x),
    .in_vel_y    (in_vel_y),
    .in_yaw_rate (in_yaw_rate),
    .half_track  (half_track_r),
    .half_base   (half_base_r),
    .q_full      (mid_full),
    .in_full     (in_full),
    .q_push      (mid_push),
    .q_item      (mid_wr)
  );

  swk_fifo #(
    .WIDTH (WHEEL_W),
    .DEPTH (MID_DEPTH)
  ) u_mid_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (mid_push),
    .push_data (mid_wr),
    .pop       (issue),
    .pop_data  (mid_rd_data),
    .full      (mid_full),
    .empty     (mid_empty),
    .count     (mid_count)
  );

  assign mid_head   = swk_wheel_t'(mid_rd_data);
  assign credit_sum = {1'b0, out_count} + {1'b0, inflight_r};
  assign issue      = !mid_empty && (credit_sum < (CNT_W+1)'(OUT_DEPTH));

  swk_back #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .wheel_valid (issue),
    .wheel_in    (mid_head),
    .rpm_scale   (rpm_scale_r),
    .res_valid   (res_valid),
    .res_out     (res_item)
  );

  always_comb begin
    inflight_nxt = inflight_r;
    if (issue && !res_valid) begin
      inflight_nxt = inflight_r + CNT_W'(1);
    end else if (res_valid && !issue) begin
      inflight_nxt = inflight_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inflight_r <= '0;
    end else begin
      inflight_r <= inflight_nxt;
    end
  end

  swk_fifo #(
    .WIDTH (RES_W),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_valid),
    .push_data (res_item),
    .pop       (out_pop),
    .pop_data  (out_rd_data),
    .full      (out_full),
    .empty     (out_empty),
    .count     (out_count)
  );

  assign out_head        = swk_result_t'(out_rd_data);
  assign out_wheel_index = out_head.wheel_index;
  assign out_steer_angle = out_head.steer_angle;
  assign out_wheel_speed = out_head.wheel_speed;
  assign out_wheel_rpm   = out_head.wheel_rpm;
  assign out_last_wheel  = out_head.last_wheel;

  `SWK_ASSERT(a_credit_bound, clk, rst_n, credit_sum <= (CNT_W+1)'(OUT_DEPTH), "credit overrun")
  `SWK_ASSERT(a_no_result_drop, clk, rst_n, res_valid |-> !out_full, "result queue overflow")
  `SWK_ASSERT(a_mid_bound, clk, rst_n, mid_count <= MCNT_W'(MID_DEPTH), "work queue overrun")
  `SWK_ASSERT(a_cmd_hold, clk, rst_n, (in_push && !in_full) |=> in_full, "command not held")
  `SWK_ASSERT_ALWAYS(a_reset_idle, clk, !rst_n |=> (out_empty && !in_full), "not idle after reset")

endmodule
`default_nettype wire

// ----- src/swk_fifo.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Swerve kinematics queue
// Show-ahead register queue with occupancy count; depth is a power of two.
// ----------------------------------------------------------------------------
module swk_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         push,
  input  logic [WIDTH-1:0]             push_data,
  input  logic                         pop,
  output logic [WIDTH-1:0]             pop_data,
  output logic                         full,
  output logic                         empty,
  output logic [$clog2(DEPTH+1)-1:0]   count
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] data_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign full     = (count_r == CNT_W'(DEPTH));
  assign empty    = (count_r == '0);
  assign count    = count_r;
  assign pop_data = data_r[rd_ptr_r];
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + PTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + PTR_W'(1) : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      data_r[wr_ptr_r] <= push_data;
    end
  end

endmodule
`default_nettype wire

// ----- src/swk_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Swerve kinematics front end
// Takes a body command, scales the yaw rate by the chassis offsets and
// hands out one wheel vector per cycle to the work queue while it is not full.
// ----------------------------------------------------------------------------
module swk_front
  import swk_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_push,
  input  logic signed [VEL_W-1:0]  in_vel_x,
  input  logic signed [VEL_W-1:0]  in_vel_y,
  input  logic signed [VEL_W-1:0]  in_yaw_rate,
  input  logic [LEN_W-1:0]         half_track,
  input  logic [LEN_W-1:0]         half_base,
  input  logic                     q_full,
  output logic                     in_full,
  output logic                     q_push,
  output swk_wheel_t               q_item
);

  logic signed [PROD_W-1:0] dw_prod, lw_prod;
  logic signed [VEL_W-1:0]  vx_r, vy_r;
  logic signed [COMP_W-1:0] dw_r, lw_r;
  logic                     wpos_r;
  logic                     cmd_v_r, cmd_v_nxt;
  logic [IDX_W-1:0]         cnt_r, cnt_nxt;
  logic                     accept, last;
  logic signed [COMP_W-1:0] vx_e, vy_e;

  assign dw_prod = signed'({1'b0, half_track}) * in_yaw_rate;
  assign lw_prod = signed'({1'b0, half_base}) * in_yaw_rate;

  assign last    = (cnt_r == LAST_WHEEL);
  assign q_push  = cmd_v_r && !q_full;
  assign in_full = cmd_v_r && !(q_push && last);
  assign accept  = in_push && !in_full;

  assign vx_e = COMP_W'(vx_r);
  assign vy_e = COMP_W'(vy_r);

  always_comb begin
    q_item.idx   = cnt_r;
    q_item.w_pos = wpos_r;
    q_item.x     = cnt_r[1] ? vx_e + dw_r : vx_e - dw_r;
    q_item.y     = (cnt_r[1] == cnt_r[0]) ? vy_e + lw_r : vy_e - lw_r;
  end

  always_comb begin
    cmd_v_nxt = cmd_v_r;
    cnt_nxt   = cnt_r;
    if (accept) begin
      cmd_v_nxt = 1'b1;
      cnt_nxt   = '0;
    end else if (q_push && last) begin
      cmd_v_nxt = 1'b0;
    end else if (q_push) begin
      cnt_nxt = cnt_r + IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmd_v_r <= 1'b0;
      cnt_r   <= '0;
    end else begin
      cmd_v_r <= cmd_v_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      vx_r   <= in_vel_x;
      vy_r   <= in_vel_y;
      dw_r   <= dw_prod[PROD_W-1:LEN_SHIFT];
      lw_r   <= lw_prod[PROD_W-1:LEN_SHIFT];
      wpos_r <= !in_yaw_rate[VEL_W-1] && (in_yaw_rate != '0);
    end
  end

endmodule
`default_nettype wire

// ----- src/swk_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Swerve kinematics back end
// Pipelined vectoring CORDIC for the steering angle, running beside a
// pipelined integer square root for the speed, then the rpm scaling.
// ----------------------------------------------------------------------------
module swk_back
  import swk_pkg::*;
#(
  parameter int CORDIC_STEPS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                wheel_valid,
  input  swk_wheel_t          wheel_in,
  input  logic [SCALE_W-1:0]  rpm_scale,
  output logic                res_valid,
  output swk_result_t         res_out
);

  localparam int ITER_N = (CORDIC_STEPS > ROOT_STEPS) ? CORDIC_STEPS : ROOT_STEPS;
  localparam int PRODR_W = SPD_W + SCALE_W;

  logic                       neg_x;
  logic signed [COMP_W-1:0]   ax, ay;
  logic signed [2*COMP_W-1:0] sqx_full, sqy_full;

  logic                     vld_a_r;
  logic [SQ_W-1:0]          sqx_a_r, sqy_a_r;
  logic signed [CDC_W-1:0]  cx_a_r, cy_a_r;
  logic [IDX_W-1:0]         idx_a_r;
  logic                     wpos_a_r, xz_a_r, yz_a_r;

  logic [SQ_W-1:0]  sum_b;
  swk_iter_t        iter_b;
  swk_iter_t        iter_r [ITER_N+1];
  logic             ivld_r [ITER_N+1];

  swk_iter_t                fin;
  logic signed [Z_W-1:0]    z_rnd, hp_z;
  logic signed [ANG_W-1:0]  ang_cdc, ang_sel;
  logic                     vld_c_r;
  logic [IDX_W-1:0]         idx_c_r;
  logic signed [ANG_W-1:0]  ang_c_r;
  logic [SPD_W-1:0]         spd_c_r;

  logic [PRODR_W-1:0]       rpm_prod;
  logic [RPM_W-1:0]         rpm_sel;

  assign neg_x    = wheel_in.x[COMP_W-1];
  assign ax       = neg_x ? -wheel_in.x : wheel_in.x;
  assign ay       = neg_x ? -wheel_in.y : wheel_in.y;
  assign sqx_full = wheel_in.x * wheel_in.x;
  assign sqy_full = wheel_in.y * wheel_in.y;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_a_r <= 1'b0;
    end else begin
      vld_a_r <= wheel_valid;
    end
  end

  always_ff @(posedge clk) begin
    sqx_a_r  <= sqx_full[SQ_W-1:0];
    sqy_a_r  <= sqy_full[SQ_W-1:0];
    cx_a_r   <= CDC_W'(ax) <<< CDC_PRESCL;
    cy_a_r   <= CDC_W'(ay) <<< CDC_PRESCL;
    idx_a_r  <= wheel_in.idx;
    wpos_a_r <= wheel_in.w_pos;
    xz_a_r   <= (wheel_in.x == '0);
    yz_a_r   <= (wheel_in.y == '0);
  end

  always_comb begin
    sum_b         = sqx_a_r + sqy_a_r;
    iter_b.idx    = idx_a_r;
    iter_b.w_pos  = wpos_a_r;
    iter_b.x_zero = xz_a_r;
    iter_b.y_zero = yz_a_r;
    iter_b.sat    = |sum_b[SQ_W-1:RAD_W];
    iter_b.cx     = cx_a_r;
    iter_b.cy     = cy_a_r;
    iter_b.cz     = '0;
    iter_b.rem    = sum_b[RAD_W-1:0];
    iter_b.root   = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ivld_r[0] <= 1'b0;
    end else begin
      ivld_r[0] <= vld_a_r;
    end
  end

  always_ff @(posedge clk) begin
    iter_r[0] <= iter_b;
  end

  for (genvar j = 0; j < ITER_N; j++) begin : g_iter
    localparam bit DO_CDC = (j < CORDIC_STEPS);
    localparam bit DO_SQR = (j < ROOT_STEPS);
    localparam logic signed [Z_W-1:0] ATAN_J = Z_W'({2'b00, ATAN_Q30[j % ATAN_LEN]});
    localparam logic [ROOT_W-1:0] SQ_BIT =
      DO_SQR ? ROOT_W'(1) << (RAD_W - 2 - 2 * (j % ROOT_STEPS)) : '0;

    swk_iter_t          cur, nxt;
    logic [ROOT_W-1:0]  trial;

    assign cur   = iter_r[j];
    assign trial = cur.root + SQ_BIT;

    always_comb begin
      nxt = cur;
      if (DO_CDC) begin
        if (!cur.cy[CDC_W-1]) begin
          nxt.cx = cur.cx + (cur.cy >>> j);
          nxt.cy = cur.cy - (cur.cx >>> j);
          nxt.cz = cur.cz + ATAN_J;
        end else begin
          nxt.cx = cur.cx - (cur.cy >>> j);
          nxt.cy = cur.cy + (cur.cx >>> j);
          nxt.cz = cur.cz - ATAN_J;
        end
      end
      if (DO_SQR) begin
        if ({1'b0, cur.rem} >= trial) begin
          nxt.rem  = cur.rem - trial[RAD_W-1:0];
          nxt.root = (cur.root >> 1) + SQ_BIT;
        end else begin
          nxt.root = cur.root >> 1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        ivld_r[j+1] <= 1'b0;
      end else begin
        ivld_r[j+1] <= ivld_r[j];
      end
    end

    always_ff @(posedge clk) begin
      iter_r[j+1] <= nxt;
    end
  end

  assign fin   = iter_r[ITER_N];
  assign z_rnd = (fin.cz + Z_ROUND) >>> Z_SHIFT;
  assign hp_z  = Z_W'(HALF_PI_Q13);

  always_comb begin
    if (z_rnd > hp_z) begin
      ang_cdc = HALF_PI_Q13;
    end else if (z_rnd < -hp_z) begin
      ang_cdc = -HALF_PI_Q13;
    end else begin
      ang_cdc = z_rnd[ANG_W-1:0];
    end
  end

  always_comb begin
    priority if (fin.x_zero && fin.y_zero) begin
      ang_sel = '0;
    end else if (fin.x_zero) begin
      ang_sel = fin.w_pos ? HALF_PI_Q13 : -HALF_PI_Q13;
    end else if (fin.y_zero) begin
      ang_sel = '0;
    end else begin
      ang_sel = ang_cdc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_c_r <= 1'b0;
    end else begin
      vld_c_r <= ivld_r[ITER_N];
    end
  end

  always_ff @(posedge clk) begin
    idx_c_r <= fin.idx;
    ang_c_r <= ang_sel;
    spd_c_r <= fin.sat ? SPEED_MAX : fin.root[SPD_W-1:0];
  end

  assign rpm_prod = spd_c_r * rpm_scale;
  assign rpm_sel  = (|rpm_prod[PRODR_W-1:RPM_SHIFT+RPM_W]) ? RPM_MAX
                    : rpm_prod[RPM_SHIFT+RPM_W-1:RPM_SHIFT];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_valid <= 1'b0;
    end else begin
      res_valid <= vld_c_r;
    end
  end

  always_ff @(posedge clk) begin
    res_out.wheel_index <= idx_c_r;
    res_out.steer_angle <= ang_c_r;
    res_out.wheel_speed <= spd_c_r;
    res_out.wheel_rpm   <= rpm_sel;
    res_out.last_wheel  <= (idx_c_r == LAST_WHEEL);
  end

endmodule
`default_nettype wire
